// ===== rtl/mse_pkg.sv =====
// ---------------------------------------------------------------------------
// mse_pkg
// Opcodes, function codes, status codes and FSM states of the execute unit.
// ---------------------------------------------------------------------------
package mse_pkg;

    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2B;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_OP  = 2'd1;
    localparam logic [1:0] ST_DIV0    = 2'd2;

    localparam int unsigned ROTR_POS  = 21;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC,
        S_MUL,
        S_DIV,
        S_MEM,
        S_DONE
    } t_state;

endpackage

// ===== rtl/mse_divider.sv =====
// ---------------------------------------------------------------------------
// mse_divider
// Signed 32-bit divider, one quotient bit per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module mse_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quot,
    output logic [31:0] o_rem
);
    logic        r_busy;
    logic [5:0]  r_cnt;
    logic [31:0] r_q;
    logic [32:0] r_r;
    logic [31:0] r_d;
    logic        r_qneg;
    logic        r_rneg;
    logic [32:0] n_trial;
    logic [32:0] n_shift;

    assign n_shift = {r_r[31:0], r_q[31]};
    assign n_trial = n_shift - {1'b0, r_d};

    // Restoring division over the magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_q    <= i_dividend[31] ? (32'd0 - i_dividend) : i_dividend;
                r_d    <= i_divisor[31] ? (32'd0 - i_divisor) : i_divisor;
                r_r    <= '0;
                r_qneg <= i_dividend[31] ^ i_divisor[31];
                r_rneg <= i_dividend[31];
            end else if (r_busy) begin
                if (n_trial[32]) begin
                    r_r <= n_shift;
                    r_q <= {r_q[30:0], 1'b0};
                end else begin
                    r_r <= n_trial;
                    r_q <= {r_q[30:0], 1'b1};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quot = r_qneg ? (32'd0 - r_q) : r_q;
    assign o_rem  = r_rneg ? (32'd0 - r_r[31:0]) : r_r[31:0];
endmodule

// ===== rtl/mips_subset_execute_unit_top.sv =====
// ---------------------------------------------------------------------------
// mips_subset_execute_unit_top
// Multi-cycle execute unit for a MIPS32 integer subset.
// ---------------------------------------------------------------------------
// One instruction item is taken at a time. An ordinary instruction passes
// through the idle state that accepts it, the register file read, execute,
// and the state that shows the result until it is taken. LW adds a state
// for the data memory read, MULT adds a state for the registered product,
// and DIV adds a state that waits for the bit-serial divider (a divide by
// zero skips the divider). The register file and the data memory are
// synchronous RAMs with registered reads. After reset a clearing pass
// writes zero to every data memory word and register, stepping over the
// larger of DATA_WORDS and 32 addresses, during which no item is accepted.
module mips_subset_execute_unit_top #(
    parameter int DATA_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_start_address,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_instruction_word,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_next_pc,
    output logic        o_reg_write_enable,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_mem_write_enable,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_mem_write_data,
    output logic [31:0] o_hi_value,
    output logic [31:0] o_lo_value,
    output logic        o_syscall_seen,
    output logic [1:0]  o_status
);
    localparam int AW = (DATA_WORDS > 1) ? $clog2(DATA_WORDS) : 1;
    localparam int CLR_WORDS = (DATA_WORDS > 32) ? DATA_WORDS : 32;
    localparam int CW = $clog2(CLR_WORDS);

    mse_pkg::t_state r_state, n_state;

    logic [31:0] r_rf [0:31];
    logic [31:0] r_dm [0:DATA_WORDS-1];
    logic [CW-1:0] r_clr;

    logic [31:0] r_pc, r_hi, r_lo, r_ir;
    logic [31:0] r_a, r_b, r_dm_q;
    logic [63:0] r_prod;

    logic [5:0]  w_op, w_fn;
    logic [4:0]  w_rs, w_rt, w_rd, w_sa;
    logic [31:0] w_sext, w_pc4, w_addr, w_brt;
    logic [AW-1:0] w_idx;

    // Result registers and their next values
    logic [31:0] r_npc, r_wval, r_maddr, r_mdata;
    logic [4:0]  r_widx;
    logic        r_wen, r_men, r_sys;
    logic [1:0]  r_stat;
    logic [31:0] n_npc, n_wval, n_maddr, n_mdata;
    logic [4:0]  n_widx;
    logic        n_wen, n_men, n_sys;
    logic [1:0]  n_stat;

    logic        w_div_start, w_div_done;
    logic [31:0] w_quot, w_rem;
    logic        w_wr;

    assign w_op   = r_ir[31:26];
    assign w_fn   = r_ir[5:0];
    assign w_rs   = r_ir[25:21];
    assign w_rt   = r_ir[20:16];
    assign w_rd   = r_ir[15:11];
    assign w_sa   = r_ir[10:6];
    assign w_sext = {{16{r_ir[15]}}, r_ir[15:0]};
    assign w_pc4  = r_pc + 32'd4;
    assign w_brt  = w_pc4 + {w_sext[29:0], 2'b00};
    assign w_addr = r_a + {w_sext[29:0], 2'b00};
    assign w_idx  = w_addr[AW+1:2];
    assign w_wr   = r_wen && (r_widx != 5'd0);

    assign o_ready     = (r_state == mse_pkg::S_IDLE);
    assign o_cfg_ready = (r_state == mse_pkg::S_IDLE);
    assign o_valid     = (r_state == mse_pkg::S_DONE);
    assign w_div_start = (r_state == mse_pkg::S_EXEC) && (w_op == mse_pkg::OP_SPECIAL)
                         && (w_fn == mse_pkg::FN_DIV) && (r_b != 32'd0);

    mse_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_a),
        .i_divisor  (r_b),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mse_pkg::S_CLEAR: if (r_clr == CW'(CLR_WORDS - 1)) n_state = mse_pkg::S_IDLE;
            mse_pkg::S_IDLE:  if (i_valid) n_state = mse_pkg::S_READ;
            mse_pkg::S_READ:  n_state = mse_pkg::S_EXEC;
            mse_pkg::S_EXEC: begin
                if (w_op == mse_pkg::OP_SPECIAL && w_fn == mse_pkg::FN_MULT)
                    n_state = mse_pkg::S_MUL;
                else if (w_div_start)
                    n_state = mse_pkg::S_DIV;
                else if (w_op == mse_pkg::OP_LW)
                    n_state = mse_pkg::S_MEM;
                else
                    n_state = mse_pkg::S_DONE;
            end
            mse_pkg::S_MUL:  n_state = mse_pkg::S_DONE;
            mse_pkg::S_DIV:  if (w_div_done) n_state = mse_pkg::S_DONE;
            mse_pkg::S_MEM:  n_state = mse_pkg::S_DONE;
            mse_pkg::S_DONE: if (i_ready) n_state = mse_pkg::S_IDLE;
            default:         n_state = mse_pkg::S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mse_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Register file: clear, read, write back
    always_ff @(posedge i_clk) begin
        if (r_state == mse_pkg::S_CLEAR) begin
            r_rf[r_clr[4:0]] <= '0;
        end else if (r_state == mse_pkg::S_DONE && i_ready && w_wr) begin
            r_rf[r_widx] <= r_wval;
        end
        if (r_state == mse_pkg::S_READ) begin
            r_a <= r_rf[w_rs];
            r_b <= r_rf[w_rt];
        end
    end

    // Data memory: clear, read for LW, write for SW
    always_ff @(posedge i_clk) begin
        if (r_state == mse_pkg::S_CLEAR) begin
            r_dm[r_clr[AW-1:0]] <= '0;
        end else if (r_state == mse_pkg::S_EXEC && w_op == mse_pkg::OP_SW) begin
            r_dm[w_idx] <= r_b;
        end
        r_dm_q <= r_dm[w_idx];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
            r_pc  <= '0;
            r_hi  <= '0;
            r_lo  <= '0;
        end else begin
            if (r_state == mse_pkg::S_CLEAR) r_clr <= r_clr + CW'(1);
            if (r_state == mse_pkg::S_IDLE && i_cfg_valid) r_pc <= i_start_address;
            if (r_state == mse_pkg::S_MUL) begin
                r_hi <= r_prod[63:32];
                r_lo <= r_prod[31:0];
            end
            if (r_state == mse_pkg::S_DIV && w_div_done) begin
                r_hi <= w_rem;
                r_lo <= w_quot;
            end
            if (r_state == mse_pkg::S_DONE && i_ready) r_pc <= r_npc;
        end
    end

    // Decode and execute the held word
    always_comb begin
        n_npc   = w_pc4;
        n_wen   = 1'b0;
        n_widx  = '0;
        n_wval  = '0;
        n_men   = 1'b0;
        n_maddr = '0;
        n_mdata = '0;
        n_sys   = 1'b0;
        n_stat  = mse_pkg::ST_OK;
        if (w_op == mse_pkg::OP_SPECIAL) begin
            case (w_fn)
                mse_pkg::FN_ADD:  begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_a + r_b; end
                mse_pkg::FN_SUB:  begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_a - r_b; end
                mse_pkg::FN_AND:  begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_a & r_b; end
                mse_pkg::FN_OR:   begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_a | r_b; end
                mse_pkg::FN_XOR:  begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_a ^ r_b; end
                mse_pkg::FN_SLT:  begin
                    n_wen = 1'b1; n_widx = w_rd;
                    n_wval = {31'd0, $signed(r_a) < $signed(r_b)};
                end
                mse_pkg::FN_SLL:  begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_b << w_sa; end
                mse_pkg::FN_SRL:  begin
                    n_wen = 1'b1; n_widx = w_rd;
                    if (r_ir[mse_pkg::ROTR_POS])
                        n_wval = (r_b >> w_sa) | (r_b << (6'd32 - {1'b0, w_sa}));
                    else
                        n_wval = r_b >> w_sa;
                end
                mse_pkg::FN_MFHI: begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_hi; end
                mse_pkg::FN_MFLO: begin n_wen = 1'b1; n_widx = w_rd; n_wval = r_lo; end
                mse_pkg::FN_JR:      n_npc = r_a;
                mse_pkg::FN_SYSCALL: n_sys = 1'b1;
                mse_pkg::FN_MULT:    ;
                mse_pkg::FN_DIV:     if (r_b == 32'd0) n_stat = mse_pkg::ST_DIV0;
                default:             n_stat = mse_pkg::ST_BAD_OP;
            endcase
        end else begin
            case (w_op)
                mse_pkg::OP_ADDI: begin n_wen = 1'b1; n_widx = w_rt; n_wval = r_a + w_sext; end
                mse_pkg::OP_LUI:  begin
                    n_wen = 1'b1; n_widx = w_rt; n_wval = {r_ir[15:0], 16'd0};
                end
                mse_pkg::OP_BEQ:  if (r_a == r_b) n_npc = w_brt;
                mse_pkg::OP_BNE:  if (r_a != r_b) n_npc = w_brt;
                mse_pkg::OP_BLEZ: if ($signed(r_a) <= 0) n_npc = w_brt;
                mse_pkg::OP_BGTZ: if ($signed(r_a) > 0) n_npc = w_brt;
                mse_pkg::OP_J:    n_npc = {w_pc4[31:28], r_ir[25:0], 2'b00};
                mse_pkg::OP_JAL:  begin
                    n_npc = {w_pc4[31:28], r_ir[25:0], 2'b00};
                    n_wen = 1'b1; n_widx = 5'd31; n_wval = w_pc4;
                end
                mse_pkg::OP_LW:   begin n_wen = 1'b1; n_widx = w_rt; n_maddr = w_addr; end
                mse_pkg::OP_SW:   begin
                    n_men = 1'b1; n_maddr = w_addr; n_mdata = r_b;
                end
                default:          n_stat = mse_pkg::ST_BAD_OP;
            endcase
        end
    end

    // Hold the accepted word, the product and the result fields
    always_ff @(posedge i_clk) begin
        if (r_state == mse_pkg::S_IDLE && i_valid) r_ir <= i_instruction_word;
        r_prod <= 64'($signed(r_a) * $signed(r_b));
        if (r_state == mse_pkg::S_EXEC) begin
            r_npc   <= n_npc;
            r_wen   <= n_wen;
            r_widx  <= n_widx;
            r_wval  <= n_wval;
            r_men   <= n_men;
            r_maddr <= n_maddr;
            r_mdata <= n_mdata;
            r_sys   <= n_sys;
            r_stat  <= n_stat;
        end else if (r_state == mse_pkg::S_MEM) begin
            r_wval  <= r_dm_q;
        end
    end

    // Writes to register zero are not reported
    assign o_next_pc          = r_npc;
    assign o_reg_write_enable = w_wr;
    assign o_reg_write_index  = w_wr ? r_widx : 5'd0;
    assign o_reg_write_value  = w_wr ? r_wval : 32'd0;
    assign o_mem_write_enable = r_men;
    assign o_mem_address      = r_maddr;
    assign o_mem_write_data   = r_mdata;
    assign o_hi_value         = r_hi;
    assign o_lo_value         = r_lo;
    assign o_syscall_seen     = r_sys;
    assign o_status           = r_stat;
endmodule

// ===== rtl/mse_checker.sv =====
// ---------------------------------------------------------------------------
// mse_checker
// Port-level checks of the execute unit handshakes and results.
// ---------------------------------------------------------------------------
module mse_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_cfg_ready,
    input logic        o_reg_write_enable,
    input logic [4:0]  o_reg_write_index,
    input logic        o_mem_write_enable,
    input logic [1:0]  o_status,
    input logic [31:0] o_next_pc
);
    // No new item while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("ready while result pending");

    // A shown result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_next_pc)))
        else $error("result dropped");

    // Register zero is never reported as written
    a_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_reg_write_enable |-> o_reg_write_index != 5'd0)
        else $error("write to register zero");

    // Faulted instructions change nothing
    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> !o_reg_write_enable && !o_mem_write_enable)
        else $error("fault with side effect");

    // Accepted item leaves idle
    a_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready && !o_cfg_ready)
        else $error("still idle after accept");
endmodule

bind mips_subset_execute_unit_top mse_checker u_mse_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_valid            (i_valid),
    .o_ready            (o_ready),
    .o_valid            (o_valid),
    .i_ready            (i_ready),
    .o_cfg_ready        (o_cfg_ready),
    .o_reg_write_enable (o_reg_write_enable),
    .o_reg_write_index  (o_reg_write_index),
    .o_mem_write_enable (o_mem_write_enable),
    .o_status           (o_status),
    .o_next_pc          (o_next_pc)
);
